// ----- rtl/core/adt_pkg.sv -----
// Shared widths, limits and result structs of the adaptive delta encoder.
// Self-contained; imported by the interfaces, the arithmetic units and the top level.
package adt_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int PRED_W      = 18;
  localparam int MAG_W       = 17;
  localparam int STEP_W      = 15;
  localparam int Q_W         = 3;
  localparam int CODE_W      = 4;
  localparam int BYTE_W      = 8;
  localparam int FACTOR_W    = 8;
  localparam int REM_W       = MAG_W + 2;
  localparam int DIVR_W      = STEP_W + 2;
  localparam int MOVE_PROD_W = 19;
  localparam int STEP_PROD_W = 22;
  localparam int MOVE_SHIFT  = 3;
  localparam int STEP_SHIFT  = 6;
  localparam int NS_W        = STEP_PROD_W - STEP_SHIFT;
  localparam int MOVE_W      = MOVE_PROD_W - MOVE_SHIFT;

  localparam int QDIV_STEPS  = Q_W;
  localparam int SMUL_STEPS  = FACTOR_W;
  localparam int QDIV_CNT_W  = $clog2(QDIV_STEPS);
  localparam int SMUL_CNT_W  = $clog2(SMUL_STEPS);

  localparam logic [STEP_W-1:0] STEP_MIN = 15'd127;
  localparam logic [STEP_W-1:0] STEP_MAX = 15'd24576;

  typedef struct packed {
    logic           busy;
    logic           done;
    logic [Q_W-1:0] q;
  } adt_qdiv_res_t;

  typedef struct packed {
    logic                   busy;
    logic                   done;
    logic [MOVE_PROD_W-1:0] move_prod;
    logic [STEP_PROD_W-1:0] step_prod;
  } adt_smul_res_t;

  function automatic logic [FACTOR_W-1:0] step_factor(input logic [Q_W-1:0] q);
    logic [FACTOR_W-1:0] f;
    case (q) inside
      [3'd0:3'd3]: f = 8'd57;
      3'd4:        f = 8'd77;
      3'd5:        f = 8'd102;
      3'd6:        f = 8'd128;
      3'd7:        f = 8'd153;
      default:     f = 8'd57;
    endcase
    return f;
  endfunction

endpackage

// ----- rtl/core/adt_if.sv -----
// Valid/ready channel interfaces: sample beats in, packed byte beats out.
// Depends on adt_pkg for field widths.
interface adt_sample_if import adt_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       block_start;

  modport source (output valid, output sample, output block_start, input ready);
  modport sink   (input valid, input sample, input block_start, output ready);
endinterface

interface adt_byte_if import adt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] packed_byte;

  modport source (output valid, output packed_byte, input ready);
  modport sink   (input valid, input packed_byte, output ready);
endinterface

// ----- rtl/core/adpcm_delta_t_encoder.sv -----
// Top level of the 4-bit adaptive delta encoder: sequencer, predictor, step and byte packing.
// Depends on adt_pkg, adt_if, adt_qdiv and adt_smul.
//
// One signed 16-bit sample is taken per input beat and coded as a 4-bit adaptive delta
// (three magnitude bits, sign in bit 3); two codes form one output beat, the earlier
// sample in the high nibble. A sample occupies the block from acceptance to the next
// ready: the difference, its magnitude, the bit-per-cycle quotient, a hand-over, the
// bit-serial step and predictor products and the update cycle. The finished byte sits
// in an output register, so the next sample is accepted while it waits; the pairing
// sample stalls in its update cycle only if the previous byte has still not been taken.
// block_start clears predictor, step and nibble phase before its own sample is coded;
// a pending high nibble is dropped.
module adpcm_delta_t_encoder import adt_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  adt_sample_if.sink      in_ch,
  adt_byte_if.source      out_ch
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_ABS  = 4'b0010,
    S_DIV  = 4'b0100,
    S_MUL  = 4'b1000
  } adt_state_t;

  adt_state_t               state_r, state_nxt;
  logic signed [PRED_W-1:0] pred_r, pred_nxt;
  logic [STEP_W-1:0]        step_r, step_nxt;
  logic                     phase_r, phase_nxt;
  logic [CODE_W-1:0]        held_r, held_nxt;
  logic signed [PRED_W-1:0] diff_r, diff_nxt;
  logic                     neg_r, neg_nxt;
  logic [BYTE_W-1:0]        out_byte_r, out_byte_nxt;
  logic                     out_valid_r, out_valid_nxt;

  logic                     in_beat;
  logic signed [PRED_W-1:0] pred_eff;
  logic signed [PRED_W-1:0] diff_abs;
  logic                     qdiv_start;
  logic                     smul_start;
  logic                     fin_go;
  logic [MOVE_W-1:0]        move;
  logic [NS_W-1:0]          ns;
  logic [CODE_W-1:0]        code;
  adt_qdiv_res_t            qdiv_res;
  adt_smul_res_t            smul_res;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_beat     = in_ch.valid && in_ch.ready;
  assign pred_eff    = in_ch.block_start ? '0 : pred_r;
  assign diff_abs    = diff_r[PRED_W-1] ? -diff_r : diff_r;
  assign qdiv_start  = (state_r == S_ABS);
  assign smul_start  = (state_r == S_DIV) && qdiv_res.done;
  assign move        = smul_res.move_prod[MOVE_PROD_W-1:MOVE_SHIFT];
  assign ns          = smul_res.step_prod[STEP_PROD_W-1:STEP_SHIFT];
  assign code        = {neg_r, qdiv_res.q};
  assign fin_go      = (state_r == S_MUL) && smul_res.done &&
                       (!phase_r || !out_valid_r || out_ch.ready);

  adt_qdiv u_qdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (qdiv_start),
    .mag   (diff_abs[MAG_W-1:0]),
    .step  (step_r),
    .res   (qdiv_res)
  );

  adt_smul u_smul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (smul_start),
    .q     (qdiv_res.q),
    .step  (step_r),
    .res   (smul_res)
  );

  always_comb begin
    state_nxt     = state_r;
    pred_nxt      = pred_r;
    step_nxt      = step_r;
    phase_nxt     = phase_r;
    held_nxt      = held_r;
    diff_nxt      = diff_r;
    neg_nxt       = neg_r;
    out_byte_nxt  = out_byte_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    case (state_r)
      S_IDLE: begin
        if (in_beat) begin
          diff_nxt  = PRED_W'(signed'(in_ch.sample)) - pred_eff;
          state_nxt = S_ABS;
          if (in_ch.block_start) begin
            pred_nxt  = '0;
            step_nxt  = STEP_MIN;
            phase_nxt = 1'b0;
            held_nxt  = '0;
          end
        end
      end
      S_ABS: begin
        neg_nxt   = diff_r[PRED_W-1];
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (qdiv_res.done) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        if (fin_go) begin
          pred_nxt = neg_r ? pred_r - PRED_W'(move) : pred_r + PRED_W'(move);
          if (ns < NS_W'(STEP_MIN)) begin
            step_nxt = STEP_MIN;
          end else if (ns > NS_W'(STEP_MAX)) begin
            step_nxt = STEP_MAX;
          end else begin
            step_nxt = ns[STEP_W-1:0];
          end
          if (!phase_r) begin
            held_nxt  = code;
            phase_nxt = 1'b1;
          end else begin
            out_byte_nxt  = {held_r, code};
            out_valid_nxt = 1'b1;
            phase_nxt     = 1'b0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pred_r      <= '0;
      step_r      <= STEP_MIN;
      phase_r     <= 1'b0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pred_r      <= pred_nxt;
      step_r      <= step_nxt;
      phase_r     <= phase_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    diff_r     <= diff_nxt;
    neg_r      <= neg_nxt;
    out_byte_r <= out_byte_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.packed_byte = out_byte_r;

  a_beat_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> (state_r == S_ABS))
    else $error("accepted sample did not start the coding sequence");

  a_ready_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (qdiv_res.busy || smul_res.busy) |-> !in_ch.ready)
    else $error("input ready while an arithmetic unit is busy");

  a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r >= STEP_MIN) && (step_r <= STEP_MAX))
    else $error("step size outside its clamp range");

  a_odd_emits_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_go && phase_r) |=> (out_valid_r && !phase_r))
    else $error("odd sample did not load an output byte");

endmodule

// ----- rtl/core/adt_qdiv.sv -----
// Restoring quotient unit: one code bit per cycle of floor(4*mag/step), saturating at 7.
// Depends on adt_pkg.
module adt_qdiv import adt_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [MAG_W-1:0]    mag,
  input  logic [STEP_W-1:0]   step,
  output adt_qdiv_res_t       res
);

  logic [REM_W-1:0]      rem_r, rem_nxt;
  logic [DIVR_W-1:0]     div_r, div_nxt;
  logic [Q_W-1:0]        q_r, q_nxt;
  logic [QDIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic                  fits;

  assign fits = rem_r >= {{(REM_W - DIVR_W){1'b0}}, div_r};

  always_comb begin
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    if (start) begin
      rem_nxt  = {mag, 2'b00};
      div_nxt  = {step, 2'b00};
      q_nxt    = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end else if (busy_r) begin
      if (fits) begin
        rem_nxt = rem_r - {{(REM_W - DIVR_W){1'b0}}, div_r};
      end
      q_nxt   = {q_r[Q_W-2:0], fits};
      div_nxt = div_r >> 1;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == QDIV_CNT_W'(QDIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    div_r <= div_nxt;
    q_r   <= q_nxt;
  end

  assign res.busy = busy_r;
  assign res.done = done_r;
  assign res.q    = q_r;

endmodule

// ----- rtl/core/adt_smul.sv -----
// Bit-serial multiplier pair: step times (2q+1) and step times the adaptation factor,
// one multiplier bit per cycle, MSB first. Depends on adt_pkg.
module adt_smul import adt_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [Q_W-1:0]      q,
  input  logic [STEP_W-1:0]   step,
  output adt_smul_res_t       res
);

  logic [FACTOR_W-1:0]    m_move_r, m_move_nxt;
  logic [FACTOR_W-1:0]    m_step_r, m_step_nxt;
  logic [MOVE_PROD_W-1:0] acc_move_r, acc_move_nxt;
  logic [STEP_PROD_W-1:0] acc_step_r, acc_step_nxt;
  logic [SMUL_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [MOVE_PROD_W-1:0] add_move;
  logic [STEP_PROD_W-1:0] add_step;

  assign add_move = m_move_r[FACTOR_W-1] ? MOVE_PROD_W'(step) : '0;
  assign add_step = m_step_r[FACTOR_W-1] ? STEP_PROD_W'(step) : '0;

  always_comb begin
    m_move_nxt   = m_move_r;
    m_step_nxt   = m_step_r;
    acc_move_nxt = acc_move_r;
    acc_step_nxt = acc_step_r;
    cnt_nxt      = cnt_r;
    busy_nxt     = busy_r;
    done_nxt     = done_r;
    if (start) begin
      m_move_nxt   = FACTOR_W'({q, 1'b1});
      m_step_nxt   = step_factor(q);
      acc_move_nxt = '0;
      acc_step_nxt = '0;
      cnt_nxt      = '0;
      busy_nxt     = 1'b1;
      done_nxt     = 1'b0;
    end else if (busy_r) begin
      acc_move_nxt = {acc_move_r[MOVE_PROD_W-2:0], 1'b0} + add_move;
      acc_step_nxt = {acc_step_r[STEP_PROD_W-2:0], 1'b0} + add_step;
      m_move_nxt   = m_move_r << 1;
      m_step_nxt   = m_step_r << 1;
      cnt_nxt      = cnt_r + 1'b1;
      if (cnt_r == SMUL_CNT_W'(SMUL_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    m_move_r   <= m_move_nxt;
    m_step_r   <= m_step_nxt;
    acc_move_r <= acc_move_nxt;
    acc_step_r <= acc_step_nxt;
  end

  assign res.busy      = busy_r;
  assign res.done      = done_r;
  assign res.move_prod = acc_move_r;
  assign res.step_prod = acc_step_r;

endmodule

// ----- dv/adt_encoder_checker.sv -----
// Scoreboard for the adaptive delta encoder: watches both channels, recomputes every code pair.
// Needs adt_pkg for widths and step limits; driven purely from the channel signals.
module adt_encoder_checker import adt_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                       in_block_start,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [BYTE_W-1:0]          out_packed_byte,
  output int                         fail_count,
  output int                         bytes_due,
  output int                         bytes_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RESCALE [8] = '{57, 57, 57, 57, 77, 102, 128, 153};

  logic signed [PRED_W-1:0] pred_level;
  logic [STEP_W-1:0]        step_level;
  logic                     odd_half;
  logic [CODE_W-1:0]        high_code;
  logic [BYTE_W-1:0]        pending_bytes [$];

  function automatic void code_sample(input logic signed [SAMPLE_W-1:0] smp,
                                      input logic restart, output logic emit,
                                      output logic [BYTE_W-1:0] pair);
    int          diff;
    int          move;
    int unsigned mag;
    int unsigned q;
    int unsigned ns;
    int unsigned step_u;
    logic        neg;
    logic [CODE_W-1:0] code;
    if (restart) begin
      pred_level = '0;
      step_level = STEP_MIN;
      odd_half   = 1'b0;
      high_code  = '0;
    end
    step_u = step_level;
    diff   = int'(smp) - int'(pred_level);
    neg    = diff < 0;
    mag    = neg ? -diff : diff;
    q      = (mag * 4) / step_u;
    if (q > 7) q = 7;
    move = int'(((2 * q + 1) * step_u) >> 3);
    pred_level = PRED_W'(int'(pred_level) + (neg ? -move : move));
    code = {neg, 3'(q)};
    ns = (RESCALE[q] * step_u) / 64;
    if (ns < STEP_MIN) ns = STEP_MIN;
    else if (ns > STEP_MAX) ns = STEP_MAX;
    step_level = STEP_W'(ns);
    if (!odd_half) begin
      high_code = code;
      odd_half  = 1'b1;
      emit      = 1'b0;
      pair      = '0;
    end else begin
      odd_half = 1'b0;
      emit     = 1'b1;
      pair     = {high_code, code};
    end
  endfunction

  task automatic note_mismatch(input string what, input logic [BYTE_W-1:0] want,
                               input logic [BYTE_W-1:0] got);
    fail_count++;
    if (fail_count <= 10)
      $display("[%0t] packed byte %s: expected %02h, got %02h", $time, what, want, got);
  endtask

  always @(posedge clk) begin : watch
    logic              emit;
    logic [BYTE_W-1:0] pair;
    logic [BYTE_W-1:0] want;
    if (!rst_n) begin
      pred_level    = '0;
      step_level    = STEP_MIN;
      odd_half      = 1'b0;
      high_code     = '0;
      fail_count    = 0;
      bytes_checked = 0;
      pending_bytes.delete();
    end else begin
      if (out_valid && out_ready) begin
        bytes_checked++;
        if (pending_bytes.size() == 0) begin
          note_mismatch("unexpected", '0, out_packed_byte);
        end else begin
          want = pending_bytes.pop_front();
          if (want !== out_packed_byte) note_mismatch("mismatch", want, out_packed_byte);
        end
      end
      if (in_valid && in_ready) begin
        code_sample(in_sample, in_block_start, emit, pair);
        if (emit) pending_bytes.push_back(pair);
      end
    end
    bytes_due <= pending_bytes.size();
  end

endmodule

// ----- dv/adpcm_delta_t_encoder_tb.sv -----
// Top of the encoder testbench: clock, reset, sample stimulus and output back-pressure.
// Instantiates adpcm_delta_t_encoder with the adt_if channels and adt_encoder_checker beside it.
module adpcm_delta_t_encoder_tb import adt_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic hold_req = 1'b0;
  logic rx_calm  = 1'b0;
  bit   tx_calm  = 1'b0;
  int   fail_count;
  int   bytes_due;
  int   bytes_checked;
  int   samples_sent = 0;
  int   starts_sent  = 0;

  adt_sample_if in_ch ();
  adt_byte_if   out_ch ();

  adpcm_delta_t_encoder dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  adt_encoder_checker chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_sample       (in_ch.sample),
    .in_block_start  (in_ch.block_start),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_packed_byte (out_ch.packed_byte),
    .fail_count      (fail_count),
    .bytes_due       (bytes_due),
    .bytes_checked   (bytes_checked)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  task automatic push(input logic signed [SAMPLE_W-1:0] s, input logic bs);
    while (!tx_calm && $urandom_range(99) < 35) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.sample      <= s;
    in_ch.block_start <= bs;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    samples_sent++;
    if (bs) starts_sent++;
  endtask

  initial begin : rx_side
    bit held;
    held = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
      end else if (rx_calm) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= 35);
      end
    end
  end

  initial begin : tx_side
    int wave;
    int kind;
    logic signed [SAMPLE_W-1:0] s;
    logic bs;
    wave = 0;
    in_ch.valid       <= 1'b0;
    in_ch.sample      <= '0;
    in_ch.block_start <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    push(16'sd0, 1'b1);
    push(16'sd0, 1'b0);
    repeat (4) push(16'sd32767, 1'b0);
    repeat (4) push(-16'sd32768, 1'b0);
    repeat (3) begin
      push(16'sd32767, 1'b0);
      push(-16'sd32768, 1'b0);
    end
    // block start on the odd half: held high nibble is lost
    push(16'sd100, 1'b1);
    push(16'sd5, 1'b1);
    push(-16'sd1, 1'b0);
    push(16'sd1, 1'b1);
    push(-16'sd1, 1'b0);
    push(16'sd2, 1'b0);
    push(16'sd0, 1'b0);

    for (int i = 0; i < 950; i++) begin
      if (i == 300) hold_req <= 1'b1;
      if (i == 450) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (bytes_due != 0) @(posedge clk);
      end
      if (i == 600) begin
        tx_calm = 1'b1;
        rx_calm <= 1'b1;
      end
      if (i == 760) begin
        tx_calm = 1'b0;
        rx_calm <= 1'b0;
      end
      bs   = ($urandom_range(99) < 4);
      kind = $urandom_range(99);
      if (kind < 50) begin
        wave += int'($urandom_range(4000)) - 2000;
      end else if (kind < 70) begin
        wave += int'($urandom_range(64)) - 32;
      end
      if (wave > 32767) wave = 32767;
      if (wave < -32768) wave = -32768;
      if (kind < 70) begin
        s = 16'(wave);
      end else if (kind < 90) begin
        s = 16'($urandom);
      end else begin
        case ($urandom_range(3))
          0:       s = -16'sd32768;
          1:       s = 16'sd32767;
          2:       s = 16'sd0;
          default: s = -16'sd1;
        endcase
      end
      push(s, bs);
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (bytes_due != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Run covered %0d samples (%0d block starts) and %0d packed bytes,", samples_sent,
             starts_sent, bytes_checked);
    $display("including a long output hold-off, a drain pause and a stall-free stretch.");
    if (fail_count == 0 && bytes_due == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
